>>> design/wts_pkg.sv
`default_nettype none

package wts_pkg;

    localparam int LEN_W  = 7;
    localparam int STD_W  = 17;
    localparam int STAT_W = 2;
    localparam int PCT_W  = 21;
    localparam int AVG_W  = 19;

    localparam logic [LEN_W-1:0] LEN_RESET = 7'd7;
    localparam logic [STD_W-1:0] STD_MAX   = 17'h1FFFF;
    localparam logic [PCT_W-1:0] PCT_LIMIT = 21'd1000000;

    // twice the percent scale, for round half away from zero
    localparam int PCT_SCALE = 200;

    localparam logic [STAT_W-1:0] STAT_NONE      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OLD_ZERO  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_SATURATED = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL_LEN,
        ST_MUL_SQ,
        ST_DIFF,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_STD_GO,
        ST_STD_WAIT,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_PCT_GO,
        ST_PCT_WAIT,
        ST_DONE
    } wts_state_t;

    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } arith_cmd_t;

endpackage

`default_nettype wire

>>> design/window_temperature_statistics_unit.sv
`default_nettype none

// Sliding-window temperature statistics. Each transfer on the input channel
// carries one sample in hundredths of a degree; each sample yields exactly one
// result transfer. Once window_length samples are held, the result carries the
// population standard deviation of the window; once one more is held, it also
// carries the average increase and the whole-percent change against the sample
// one window back, with status for a zero old sample or a saturated percent.
// window_length is to be written through cfg_write_en/cfg_write_data only
// while the block is idle; the block itself does not enforce this. Zero acts
// as 1 and values above WINDOW_MAX act as WINDOW_MAX. One sample is processed
// at a time and in_ready is low until its result has been taken. With fewer
// samples than the window, the sample goes straight to the result. Otherwise
// the block accepts it, makes the ring reads (L, or L + 1 once the older sample
// exists, one per cycle through the one ring memory port), drains the read
// pipeline, then forms the square and the variance; the square root and the
// divisions run on the shared one-bit-per-cycle divide/square-root unit: one
// division for the deviation, two more once the older sample exists (one when
// it is zero), before the result is offered.

module window_temperature_statistics_unit
    import wts_pkg::*;
#(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 18
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [LEN_W-1:0]              cfg_write_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          deviation_valid,
    output logic [STD_W-1:0]              std_deviation,
    output logic [STAT_W-1:0]             evolution_status,
    output logic signed [PCT_W-1:0]       evolution_percent,
    output logic                          increase_valid,
    output logic signed [AVG_W-1:0]       average_increase
);

    localparam int RING_DEPTH = WINDOW_MAX + 1;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int NW         = $clog2(WINDOW_MAX + 1);
    localparam int S1_W       = SAMPLE_BITS + NW;
    localparam int SQ1_W      = 2 * SAMPLE_BITS;
    localparam int S2_W       = 2 * SAMPLE_BITS + NW;
    localparam int M_W        = S2_W + LEN_W;
    localparam int P_W        = 2 * S1_W;
    localparam int D_W        = (M_W > P_W) ? M_W : P_W;
    localparam int X_W        = 2 * ((D_W + 3) / 2);
    localparam int R_W        = X_W / 2;
    localparam int NUM_W      = (R_W + 1 > SAMPLE_BITS + 9) ? R_W + 1 : SAMPLE_BITS + 9;
    localparam int DEN_W      = SAMPLE_BITS + 1;
    localparam int DIFF_W     = SAMPLE_BITS + 1;
    localparam int K_W        = LEN_W + 1;

    wts_state_t state_reg, state_next;

    logic [LEN_W-1:0]              wlen_reg, wlen_next;
    logic [PTR_W-1:0]              wp_reg, wp_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [LEN_W-1:0]              len_reg, len_next;
    logic [K_W-1:0]                nreads_reg, nreads_next;
    logic [K_W-1:0]                k_reg, k_next;
    logic [PTR_W-1:0]              rptr_reg, rptr_next;
    logic                          p1_reg, p1_next;
    logic                          p1_old_reg, p1_old_next;
    logic                          p2_reg, p2_next;
    logic                          dev_valid_reg, dev_valid_next;
    logic                          inc_valid_reg, inc_valid_next;

    logic signed [SAMPLE_BITS-1:0] cur_reg, cur_next;
    logic signed [SAMPLE_BITS-1:0] old_reg, old_next;
    logic signed [SAMPLE_BITS-1:0] v_reg, v_next;
    logic [SQ1_W-1:0]              sq_reg, sq_next;
    logic signed [S1_W-1:0]        s1_reg, s1_next;
    logic [S2_W-1:0]               s2_reg, s2_next;
    logic [D_W-1:0]                m_reg, m_next;
    logic [D_W-1:0]                p_reg, p_next;
    logic [D_W-1:0]                d_reg, d_next;
    logic [R_W-1:0]                sqrt_reg, sqrt_next;
    logic [STD_W-1:0]              std_reg, std_next;
    logic [STAT_W-1:0]             status_reg, status_next;
    logic signed [PCT_W-1:0]       pct_reg, pct_next;
    logic signed [AVG_W-1:0]       avg_reg, avg_next;

    logic                          ram_we;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic                          issue;

    arith_cmd_t                    cmd;
    logic [NUM_W-1:0]              numerator;
    logic [DEN_W-1:0]              divisor;
    logic [X_W-1:0]                radicand;
    logic                          unit_done;
    logic [NUM_W-1:0]              unit_result;

    logic [LEN_W-1:0]              len_eff;
    logic [CNT_W-1:0]              cnt_inc;
    logic signed [SQ1_W-1:0]       rd_ext;
    logic [S1_W-1:0]               abs_s1;
    logic signed [DIFF_W-1:0]      diff;
    logic [DIFF_W-1:0]             abs_diff;
    logic [SAMPLE_BITS-1:0]        abs_old;
    logic                          old_zero;
    logic                          pct_neg;
    logic                          pct_sat;
    logic [PCT_W-1:0]              pct_mag;
    logic [AVG_W-1:0]              avg_mag;

    wts_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (sample),
        .raddr (rptr_reg),
        .rdata (ram_rdata)
    );

    wts_arith_unit #(
        .X_W   (X_W),
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_arith (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .radicand  (radicand),
        .numerator (numerator),
        .divisor   (divisor),
        .done      (unit_done),
        .result    (unit_result)
    );

    always_comb
    begin
        if (wlen_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (32'(wlen_reg) > 32'(WINDOW_MAX))
        begin
            len_eff = LEN_W'(WINDOW_MAX);
        end
        else
        begin
            len_eff = wlen_reg;
        end
        cnt_inc  = (32'(cnt_reg) < 32'(RING_DEPTH)) ? cnt_reg + 1'b1 : cnt_reg;
        rd_ext   = SQ1_W'($signed(ram_rdata));
        abs_s1   = s1_reg[S1_W-1] ? S1_W'(-s1_reg) : S1_W'(s1_reg);
        diff     = DIFF_W'(cur_reg) - DIFF_W'(old_reg);
        abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        abs_old  = old_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(-old_reg) : SAMPLE_BITS'(old_reg);
        old_zero = (old_reg == '0);
        pct_neg  = diff[DIFF_W-1] ^ old_reg[SAMPLE_BITS-1];
        pct_sat  = (64'(unit_result) > 64'(PCT_LIMIT));
        pct_mag  = pct_sat ? PCT_LIMIT : PCT_W'(unit_result);
        avg_mag  = AVG_W'(unit_result);
        radicand = X_W'({d_reg, 2'b00});
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (32'(cnt_inc) >= 32'(len_eff)) ? ST_SUM : ST_DONE;
                end
            end
            ST_SUM:
            begin
                if (!issue && !p1_reg && !p2_reg)
                begin
                    state_next = ST_MUL_LEN;
                end
            end
            ST_MUL_LEN:   state_next = ST_MUL_SQ;
            ST_MUL_SQ:    state_next = ST_DIFF;
            ST_DIFF:      state_next = ST_SQRT_GO;
            ST_SQRT_GO:   state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT:
            begin
                if (unit_done)
                begin
                    state_next = ST_STD_GO;
                end
            end
            ST_STD_GO:    state_next = ST_STD_WAIT;
            ST_STD_WAIT:
            begin
                if (unit_done)
                begin
                    state_next = inc_valid_reg ? ST_AVG_GO : ST_DONE;
                end
            end
            ST_AVG_GO:    state_next = ST_AVG_WAIT;
            ST_AVG_WAIT:
            begin
                if (unit_done)
                begin
                    state_next = old_zero ? ST_DONE : ST_PCT_GO;
                end
            end
            ST_PCT_GO:    state_next = ST_PCT_WAIT;
            ST_PCT_WAIT:
            begin
                if (unit_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        issue         = 1'b0;
        cmd.start     = 1'b0;
        cmd.sqrt_mode = 1'b0;
        numerator     = '0;
        divisor       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SUM:
            begin
                issue = (k_reg < nreads_reg);
            end
            ST_SQRT_GO:
            begin
                cmd.start     = 1'b1;
                cmd.sqrt_mode = 1'b1;
            end
            ST_STD_GO:
            begin
                cmd.start = 1'b1;
                numerator = NUM_W'(sqrt_reg) + NUM_W'(len_reg);
                divisor   = DEN_W'({len_reg, 1'b0});
            end
            ST_AVG_GO:
            begin
                cmd.start = 1'b1;
                numerator = NUM_W'({abs_diff, 1'b0}) + NUM_W'(len_reg);
                divisor   = DEN_W'({len_reg, 1'b0});
            end
            ST_PCT_GO:
            begin
                cmd.start = 1'b1;
                numerator = NUM_W'(abs_diff) * NUM_W'(PCT_SCALE) + NUM_W'(abs_old);
                divisor   = DEN_W'({abs_old, 1'b0});
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign ram_we = in_ready && in_valid;

    // datapath
    always_comb
    begin
        wlen_next      = cfg_write_en ? cfg_write_data : wlen_reg;
        wp_next        = wp_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        nreads_next    = nreads_reg;
        k_next         = k_reg;
        rptr_next      = rptr_reg;
        p1_next        = issue;
        p1_old_next    = (k_reg == K_W'(len_reg));
        p2_next        = p1_reg && !p1_old_reg;
        dev_valid_next = dev_valid_reg;
        inc_valid_next = inc_valid_reg;
        cur_next       = cur_reg;
        old_next       = old_reg;
        v_next         = $signed(ram_rdata);
        sq_next        = SQ1_W'(rd_ext * rd_ext);
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        m_next         = m_reg;
        p_next         = p_reg;
        d_next         = d_reg;
        sqrt_next      = sqrt_reg;
        std_next       = std_reg;
        status_next    = status_reg;
        pct_next       = pct_reg;
        avg_next       = avg_reg;

        if (ram_we)
        begin
            wp_next        = (wp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            cnt_next       = cnt_inc;
            len_next       = len_eff;
            nreads_next    = K_W'(len_eff)
                             + K_W'(32'(cnt_inc) > 32'(len_eff));
            k_next         = '0;
            rptr_next      = wp_reg;
            cur_next       = sample;
            s1_next        = '0;
            s2_next        = '0;
            dev_valid_next = (32'(cnt_inc) >= 32'(len_eff));
            inc_valid_next = (32'(cnt_inc) > 32'(len_eff));
            std_next       = '0;
            status_next    = STAT_NONE;
            pct_next       = '0;
            avg_next       = '0;
        end

        if (issue)
        begin
            k_next    = k_reg + 1'b1;
            rptr_next = (rptr_reg == '0) ? PTR_W'(RING_DEPTH - 1) : rptr_reg - 1'b1;
        end

        if (p1_reg && p1_old_reg)
        begin
            old_next = $signed(ram_rdata);
        end

        if (p2_reg)
        begin
            s1_next = s1_reg + S1_W'(v_reg);
            s2_next = s2_reg + S2_W'(sq_reg);
        end

        case (state_reg)
            ST_MUL_LEN:
            begin
                m_next = D_W'(len_reg) * D_W'(s2_reg);
            end
            ST_MUL_SQ:
            begin
                p_next = D_W'(abs_s1) * D_W'(abs_s1);
            end
            ST_DIFF:
            begin
                d_next = (m_reg > p_reg) ? m_reg - p_reg : '0;
            end
            ST_SQRT_WAIT:
            begin
                if (unit_done)
                begin
                    sqrt_next = R_W'(unit_result);
                end
            end
            ST_STD_WAIT:
            begin
                if (unit_done)
                begin
                    std_next = (64'(unit_result) > 64'(STD_MAX)) ? STD_MAX
                                                                 : STD_W'(unit_result);
                end
            end
            ST_AVG_WAIT:
            begin
                if (unit_done)
                begin
                    avg_next = diff[DIFF_W-1] ? AVG_W'(-avg_mag) : AVG_W'(avg_mag);
                    if (old_zero)
                    begin
                        status_next = STAT_OLD_ZERO;
                        pct_next    = '0;
                    end
                end
            end
            ST_PCT_WAIT:
            begin
                if (unit_done)
                begin
                    pct_next    = pct_neg ? PCT_W'(-pct_mag) : PCT_W'(pct_mag);
                    status_next = pct_sat ? STAT_SATURATED : STAT_OK;
                end
            end
            default:
            begin
                d_next = d_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wlen_reg      <= LEN_RESET;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            len_reg       <= '0;
            nreads_reg    <= '0;
            k_reg         <= '0;
            rptr_reg      <= '0;
            p1_reg        <= 1'b0;
            p1_old_reg    <= 1'b0;
            p2_reg        <= 1'b0;
            dev_valid_reg <= 1'b0;
            inc_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wlen_reg      <= wlen_next;
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            nreads_reg    <= nreads_next;
            k_reg         <= k_next;
            rptr_reg      <= rptr_next;
            p1_reg        <= p1_next;
            p1_old_reg    <= p1_old_next;
            p2_reg        <= p2_next;
            dev_valid_reg <= dev_valid_next;
            inc_valid_reg <= inc_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        old_reg    <= old_next;
        v_reg      <= v_next;
        sq_reg     <= sq_next;
        s1_reg     <= s1_next;
        s2_reg     <= s2_next;
        m_reg      <= m_next;
        p_reg      <= p_next;
        d_reg      <= d_next;
        sqrt_reg   <= sqrt_next;
        std_reg    <= std_next;
        status_reg <= status_next;
        pct_reg    <= pct_next;
        avg_reg    <= avg_next;
    end

    assign deviation_valid   = dev_valid_reg;
    assign std_deviation     = std_reg;
    assign evolution_status  = status_reg;
    assign evolution_percent = pct_reg;
    assign increase_valid    = inc_valid_reg;
    assign average_increase  = avg_reg;

endmodule

`default_nettype wire

>>> design/wts_ram.sv
`default_nettype none

module wts_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 65
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/wts_arith_unit.sv
`default_nettype none

module wts_arith_unit
    import wts_pkg::*;
#(
    parameter int X_W   = 52,
    parameter int NUM_W = 27,
    parameter int DEN_W = 19
)(
    input  logic             clk,
    input  logic             rst_n,
    input  arith_cmd_t       cmd,
    input  logic [X_W-1:0]   radicand,
    input  logic [NUM_W-1:0] numerator,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] result
);

    localparam int SQ_STEPS = X_W / 2;
    localparam int SRC_W    = (X_W > NUM_W) ? X_W : NUM_W;
    localparam int REM_W    = (SQ_STEPS + 2 > DEN_W + 1) ? SQ_STEPS + 2 : DEN_W + 1;
    localparam int STEP_MAX = (SQ_STEPS > NUM_W) ? SQ_STEPS : NUM_W;
    localparam int STEP_W   = $clog2(STEP_MAX + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              mode_reg, mode_next;
    logic [SRC_W-1:0]  src_reg, src_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  den_reg, den_next;

    logic [REM_W-1:0]  shifted;
    logic [REM_W-1:0]  trial;
    logic              fits;

    always_comb
    begin
        if (mode_reg)
        begin
            shifted = {rem_reg[REM_W-3:0], src_reg[SRC_W-1 -: 2]};
            trial   = REM_W'({quo_reg, 2'b01});
        end
        else
        begin
            shifted = {rem_reg[REM_W-2:0], src_reg[SRC_W-1]};
            trial   = REM_W'(den_reg);
        end
        fits = (shifted >= trial);
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        mode_next = mode_reg;
        src_next  = src_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            mode_next = cmd.sqrt_mode;
            rem_next  = '0;
            quo_next  = '0;
            den_next  = divisor;
            if (cmd.sqrt_mode)
            begin
                step_next = STEP_W'(SQ_STEPS);
                src_next  = SRC_W'(radicand) << (SRC_W - X_W);
            end
            else
            begin
                step_next = STEP_W'(NUM_W);
                src_next  = SRC_W'(numerator) << (SRC_W - NUM_W);
            end
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? shifted - trial : shifted;
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            src_next  = mode_reg ? (src_reg << 2) : (src_reg << 1);
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        src_reg  <= src_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
    end

    assign done   = done_reg;
    assign result = quo_reg;

endmodule

`default_nettype wire
